// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the I2C master transfer block.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_ST_SDA_LOW  = 4'd1;
	localparam logic [3:0] PH_ST_SCL_LOW  = 4'd2;
	localparam logic [3:0] PH_BIT_SETUP   = 4'd3;
	localparam logic [3:0] PH_BIT_HIGH    = 4'd4;
	localparam logic [3:0] PH_ACK_RELEASE = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH    = 4'd6;
	localparam logic [3:0] PH_ACK_WAIT    = 4'd7;
	localparam logic [3:0] PH_RD_HIGH     = 4'd8;
	localparam logic [3:0] PH_RD_SAMPLE   = 4'd9;
	localparam logic [3:0] PH_AK_HIGH     = 4'd10;
	localparam logic [3:0] PH_AK_DONE     = 4'd11;
	localparam logic [3:0] PH_SP_SCL_HIGH = 4'd12;
	localparam logic [3:0] PH_SP_SDA_HIGH = 4'd13;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NAK       = 2'd1;
	localparam logic [1:0] ST_BAD_PARAM = 2'd2;

	localparam logic [1:0] REG_DEV_ADDR    = 2'd0;
	localparam logic [1:0] REG_WRITE_COUNT = 2'd1;
	localparam logic [1:0] REG_READ_COUNT  = 2'd2;
	localparam logic [1:0] REG_ACK_TIMEOUT = 2'd3;

	localparam logic [7:0] ACK_TIMEOUT_RST = 8'd200;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

	typedef struct packed {
		logic       opcode;
		logic       sda_in;
		logic [7:0] tx_byte;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       tx_taken;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       done_res;
		logic [1:0] status;
		logic       busy_res;
	} rsp_t;

	typedef struct packed {
		logic [6:0] device_address;
		logic [7:0] write_count;
		logic [7:0] read_count;
		logic [7:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic [3:0] phase;
		logic [3:0] bit_index;
		logic [7:0] shifter;
		logic [7:0] writes_left;
		logic [7:0] reads_left;
		logic [7:0] wait_count;
		logic [1:0] result_code;
		logic       scl_drive;
		logic       sda_drive;
		logic       read_addr;
	} fsm_state_t;

endpackage

// ===== rtl/i2cm_cmd_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_cmd_if
// Input item channel: tick or begin command with sampled SDA and write byte.
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic       sda_in;
	logic [7:0] tx_byte;

	modport source(output valid, output opcode, output sda_in, output tx_byte, input ready);
	modport sink(input valid, input opcode, input sda_in, input tx_byte, output ready);
endinterface

// ===== rtl/i2cm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_rsp_if
// Result item channel: line drives, byte flags and transfer status.
// ----------------------------------------------------------------------------
interface i2cm_rsp_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       tx_taken;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic       done_res;
	logic [1:0] status;
	logic       busy_res;

	modport source(output valid, output scl_out, output sda_out, output tx_taken,
		output rx_byte, output rx_valid, output done_res, output status,
		output busy_res, input ready);
	modport sink(input valid, input scl_out, input sda_out, input tx_taken,
		input rx_byte, input rx_valid, input done_res, input status,
		input busy_res, output ready);
endinterface

// ===== rtl/i2cm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface i2cm_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/i2cm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// i2cm_cfg_regs
// Configuration register file: address, transfer counts, ack timeout.
// ----------------------------------------------------------------------------
module i2cm_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	i2cm_cfg_if.sink        cfg,
	output i2cm_pkg::cfg_t  regs
);
	import i2cm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.device_address <= '0;
			regs_q.write_count    <= '0;
			regs_q.read_count     <= '0;
			regs_q.ack_timeout    <= ACK_TIMEOUT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEV_ADDR:    regs_q.device_address <= cfg.data[6:0];
				REG_WRITE_COUNT: regs_q.write_count    <= cfg.data;
				REG_READ_COUNT:  regs_q.read_count     <= cfg.data;
				REG_ACK_TIMEOUT: regs_q.ack_timeout    <= cfg.data;
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== rtl/i2cm_fsm.sv =====
// ----------------------------------------------------------------------------
// i2cm_fsm
// Half-period bus sequencer: takes one step per item and forms its result.
// ----------------------------------------------------------------------------
module i2cm_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  i2cm_pkg::cmd_t      cmd,
	input  i2cm_pkg::cfg_t      regs,
	output i2cm_pkg::rsp_t      rsp
);
	import i2cm_pkg::*;

	fsm_state_t cur_q;
	fsm_state_t nxt;
	logic [7:0] wc_dec;
	logic [7:0] rd_shift;
	logic [3:0] bi_inc;
	logic [7:0] rl_dec;

	function automatic fsm_state_t go_stop(input fsm_state_t s);
		fsm_state_t r;
		r = s;
		r.scl_drive = 1'b0;
		r.sda_drive = 1'b0;
		r.phase     = PH_SP_SCL_HIGH;
		return r;
	endfunction

	function automatic fsm_state_t go_read(input fsm_state_t s);
		fsm_state_t r;
		r = s;
		r.sda_drive = 1'b1;
		r.scl_drive = 1'b0;
		r.shifter   = '0;
		r.bit_index = '0;
		r.phase     = PH_RD_HIGH;
		return r;
	endfunction

	function automatic fsm_state_t go_start(input fsm_state_t s, input logic rd,
		input logic [6:0] addr);
		fsm_state_t r;
		r = s;
		r.read_addr = rd;
		r.shifter   = {addr, rd};
		r.bit_index = '0;
		r.scl_drive = 1'b1;
		r.sda_drive = 1'b1;
		r.phase     = PH_ST_SDA_LOW;
		return r;
	endfunction

	assign wc_dec = cur_q.wait_count - 8'd1;
	assign bi_inc = cur_q.bit_index + 4'd1;
	assign rl_dec = cur_q.reads_left - 8'd1;

	always_comb begin
		rd_shift = cur_q.shifter;
		rd_shift[3'd7 - cur_q.bit_index[2:0]] = cur_q.shifter[3'd7 - cur_q.bit_index[2:0]]
			| cmd.sda_in;
	end

	always_comb begin
		nxt = cur_q;
		rsp = '0;
		case (cur_q.phase)
			PH_IDLE: begin
				if (cmd.opcode) begin
					nxt.writes_left = regs.write_count;
					nxt.reads_left  = regs.read_count;
					nxt.result_code = ST_OK;
					if (regs.write_count != 8'd0) begin
						nxt = go_start(nxt, 1'b0, regs.device_address);
					end else if (regs.read_count != 8'd0) begin
						nxt = go_start(nxt, 1'b1, regs.device_address);
					end else begin
						nxt.result_code = ST_BAD_PARAM;
						nxt = go_stop(nxt);
					end
				end
			end
			PH_ST_SDA_LOW: begin
				nxt.sda_drive = 1'b0;
				nxt.phase     = PH_ST_SCL_LOW;
			end
			PH_ST_SCL_LOW: begin
				nxt.scl_drive = 1'b0;
				nxt.phase     = PH_BIT_SETUP;
			end
			PH_BIT_SETUP: begin
				nxt.scl_drive = 1'b0;
				nxt.sda_drive = cur_q.shifter[3'd7 - cur_q.bit_index[2:0]];
				nxt.phase     = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				nxt.scl_drive = 1'b1;
				nxt.bit_index = bi_inc;
				nxt.phase     = (bi_inc >= BITS_PER_BYTE) ? PH_ACK_RELEASE : PH_BIT_SETUP;
			end
			PH_ACK_RELEASE: begin
				nxt.scl_drive = 1'b0;
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_ACK_HIGH;
			end
			PH_ACK_HIGH: begin
				nxt.scl_drive  = 1'b1;
				nxt.wait_count = (regs.ack_timeout != 8'd0) ? regs.ack_timeout : 8'd1;
				nxt.phase      = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				if (cmd.sda_in) begin
					nxt.wait_count = wc_dec;
					if (wc_dec == 8'd0) begin
						nxt.result_code = ST_NAK;
						nxt = go_stop(nxt);
					end
				end else begin
					nxt.scl_drive = 1'b0;
					if (cur_q.read_addr) begin
						nxt = go_read(nxt);
					end else if (cur_q.writes_left != 8'd0) begin
						nxt.shifter     = cmd.tx_byte;
						nxt.writes_left = cur_q.writes_left - 8'd1;
						nxt.bit_index   = '0;
						nxt.sda_drive   = cmd.tx_byte[7];
						nxt.phase       = PH_BIT_HIGH;
						rsp.tx_taken    = 1'b1;
					end else if (cur_q.reads_left != 8'd0) begin
						nxt = go_start(nxt, 1'b1, regs.device_address);
					end else begin
						nxt = go_stop(nxt);
					end
				end
			end
			PH_RD_HIGH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_RD_SAMPLE;
			end
			PH_RD_SAMPLE: begin
				nxt.shifter   = rd_shift;
				nxt.scl_drive = 1'b0;
				nxt.bit_index = bi_inc;
				if (bi_inc < BITS_PER_BYTE) begin
					nxt.phase = PH_RD_HIGH;
				end else begin
					rsp.rx_valid   = 1'b1;
					rsp.rx_byte    = rd_shift;
					nxt.reads_left = rl_dec;
					nxt.sda_drive  = (rl_dec == 8'd0);
					nxt.phase      = PH_AK_HIGH;
				end
			end
			PH_AK_HIGH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_AK_DONE;
			end
			PH_AK_DONE: begin
				nxt.scl_drive = 1'b0;
				if (cur_q.reads_left != 8'd0) begin
					nxt = go_read(nxt);
				end else begin
					nxt = go_stop(nxt);
				end
			end
			PH_SP_SCL_HIGH: begin
				nxt.scl_drive = 1'b1;
				nxt.phase     = PH_SP_SDA_HIGH;
			end
			PH_SP_SDA_HIGH: begin
				nxt.sda_drive = 1'b1;
				nxt.phase     = PH_IDLE;
				rsp.done_res  = 1'b1;
				rsp.status    = cur_q.result_code;
			end
			default: begin
				nxt.phase     = PH_IDLE;
				nxt.scl_drive = 1'b1;
				nxt.sda_drive = 1'b1;
			end
		endcase
		rsp.scl_out  = nxt.scl_drive;
		rsp.sda_out  = nxt.sda_drive;
		rsp.busy_res = (nxt.phase != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '{phase: PH_IDLE, bit_index: 4'd0, shifter: 8'd0, writes_left: 8'd0,
				reads_left: 8'd0, wait_count: 8'd0, result_code: ST_OK, scl_drive: 1'b1,
				sda_drive: 1'b1, read_addr: 1'b0};
		end else if (step) begin
			cur_q <= nxt;
		end
	end
endmodule

// ===== rtl/i2c_master_transfer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_top
// I2C master that runs one write/read transfer, stepped one half bit per item.
// ----------------------------------------------------------------------------
// Each command item is one half-period tick of the bus (or a begin request)
// and yields exactly one result item with the SCL/SDA drive levels that apply
// after that tick. Each item passes the input register and then the result
// register before its result is offered, and one item is taken every cycle
// while the result side keeps up; the sequencer's state register is updated
// once per item as it leaves the input register.
// Configuration writes are taken every cycle and should only be issued while
// no transfer or item is in flight.
module i2c_master_transfer_top (
	input  logic       clk,
	input  logic       arst_n,
	i2cm_cmd_if.sink   cmd,
	i2cm_rsp_if.source rsp,
	i2cm_cfg_if.sink   cfg
);
	import i2cm_pkg::*;

	cfg_t regs;
	cmd_t item_s1;
	logic valid_s1;
	rsp_t res_next;
	rsp_t res_s2;
	logic valid_s2;
	logic s2_free;
	logic step;

	assign s2_free   = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && s2_free;
	assign cmd.ready = !valid_s1 || s2_free;

	i2cm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	i2cm_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (item_s1),
		.regs   (regs),
		.rsp    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (s2_free) begin
				valid_s2 <= step;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= '{opcode: cmd.opcode, sda_in: cmd.sda_in, tx_byte: cmd.tx_byte};
		end
		if (step) begin
			res_s2 <= res_next;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.scl_out  = res_s2.scl_out;
	assign rsp.sda_out  = res_s2.sda_out;
	assign rsp.tx_taken = res_s2.tx_taken;
	assign rsp.rx_byte  = res_s2.rx_byte;
	assign rsp.rx_valid = res_s2.rx_valid;
	assign rsp.done_res = res_s2.done_res;
	assign rsp.status   = res_s2.status;
	assign rsp.busy_res = res_s2.busy_res;
endmodule

// ===== rtl/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the result stream of the I2C master transfer block.
// ----------------------------------------------------------------------------
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       scl_out,
	input logic       tx_taken,
	input logic [7:0] rx_byte,
	input logic       rx_valid,
	input logic       done_res,
	input logic [1:0] status,
	input logic       busy_res
);
	import i2cm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rx_byte) && $stable(status)
			&& $stable(done_res))
		else $error("stalled result changed");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && done_res |-> !busy_res && !tx_taken && !rx_valid)
		else $error("finished transfer still busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !done_res |-> status == ST_OK)
		else $error("status outside finish");

	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rx_valid |-> rx_byte == 8'd0)
		else $error("read byte without flag");

	a_taken: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && tx_taken |-> !scl_out && busy_res)
		else $error("write byte taken with SCL high or idle");
endmodule

bind i2c_master_transfer_top i2cm_checker u_i2cm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.scl_out   (rsp.scl_out),
	.tx_taken  (rsp.tx_taken),
	.rx_byte   (rsp.rx_byte),
	.rx_valid  (rsp.rx_valid),
	.done_res  (rsp.done_res),
	.status    (rsp.status),
	.busy_res  (rsp.busy_res)
);

// ===== test/i2c_master_transfer_check.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_check
// Watches the command, result and configuration channels of the I2C master.
// Every accepted command item is run through a half-tick model of the bus
// sequencer. The expected line drives, byte flags and status go into a
// queue. Each accepted result is compared field by field with the oldest
// entry. Mismatches, unexpected results and a count of pending results are
// handed to the test top.
// ----------------------------------------------------------------------------
module i2c_master_transfer_check (
	input  logic clk,
	input  logic arst_n,
	i2cm_cmd_if  cmd,
	i2cm_rsp_if  rsp,
	i2cm_cfg_if  cfg,
	output int   errors,
	output int   waiting,
	output logic xfer_active
);
	timeunit 1ns;
	timeprecision 1ps;
	import i2cm_pkg::*;

	fsm_state_t bus;
	cfg_t       regs;
	rsp_t       due_results[$];
	int         result_no;

	function automatic void send_address(input logic rd);
		bus.read_addr = rd;
		bus.shifter   = {regs.device_address, rd};
		bus.bit_index = '0;
		bus.scl_drive = 1'b1;
		bus.sda_drive = 1'b1;
		bus.phase     = PH_ST_SDA_LOW;
	endfunction

	function automatic void send_stop();
		bus.scl_drive = 1'b0;
		bus.sda_drive = 1'b0;
		bus.phase     = PH_SP_SCL_HIGH;
	endfunction

	function automatic void drive_bit();
		bus.scl_drive = 1'b0;
		bus.sda_drive = bus.shifter[3'd7 - bus.bit_index[2:0]];
		bus.phase     = PH_BIT_HIGH;
	endfunction

	function automatic void start_read();
		bus.sda_drive = 1'b1;
		bus.scl_drive = 1'b0;
		bus.shifter   = '0;
		bus.bit_index = '0;
		bus.phase     = PH_RD_HIGH;
	endfunction

	function automatic rsp_t half_tick(input cmd_t c);
		rsp_t r;
		logic acked;
		r = '0;
		case (bus.phase)
			PH_IDLE: begin
				if (c.opcode) begin
					bus.writes_left = regs.write_count;
					bus.reads_left  = regs.read_count;
					bus.result_code = ST_OK;
					if (bus.writes_left != 0) begin
						send_address(1'b0);
					end else if (bus.reads_left != 0) begin
						send_address(1'b1);
					end else begin
						bus.result_code = ST_BAD_PARAM;
						send_stop();
					end
				end
			end
			PH_ST_SDA_LOW: begin
				bus.sda_drive = 1'b0;
				bus.phase     = PH_ST_SCL_LOW;
			end
			PH_ST_SCL_LOW: begin
				bus.scl_drive = 1'b0;
				bus.phase     = PH_BIT_SETUP;
			end
			PH_BIT_SETUP: begin
				drive_bit();
			end
			PH_BIT_HIGH: begin
				bus.scl_drive = 1'b1;
				bus.bit_index = bus.bit_index + 4'd1;
				bus.phase = (bus.bit_index >= BITS_PER_BYTE) ? PH_ACK_RELEASE : PH_BIT_SETUP;
			end
			PH_ACK_RELEASE: begin
				bus.scl_drive = 1'b0;
				bus.sda_drive = 1'b1;
				bus.phase     = PH_ACK_HIGH;
			end
			PH_ACK_HIGH: begin
				bus.scl_drive  = 1'b1;
				bus.wait_count = (regs.ack_timeout != 0) ? regs.ack_timeout : 8'd1;
				bus.phase      = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				acked = !c.sda_in;
				if (!acked)
					bus.wait_count = bus.wait_count - 8'd1;
				if (acked || bus.wait_count == 0) begin
					bus.scl_drive = 1'b0;
					if (!acked) begin
						bus.result_code = ST_NAK;
						send_stop();
					end else if (bus.read_addr) begin
						start_read();
					end else if (bus.writes_left != 0) begin
						bus.shifter     = c.tx_byte;
						r.tx_taken      = 1'b1;
						bus.writes_left = bus.writes_left - 8'd1;
						bus.bit_index   = '0;
						drive_bit();
					end else if (bus.reads_left != 0) begin
						send_address(1'b1);
					end else begin
						send_stop();
					end
				end
			end
			PH_RD_HIGH: begin
				bus.scl_drive = 1'b1;
				bus.phase     = PH_RD_SAMPLE;
			end
			PH_RD_SAMPLE: begin
				if (c.sda_in)
					bus.shifter[3'd7 - bus.bit_index[2:0]] = 1'b1;
				bus.scl_drive = 1'b0;
				bus.bit_index = bus.bit_index + 4'd1;
				if (bus.bit_index < BITS_PER_BYTE) begin
					bus.phase = PH_RD_HIGH;
				end else begin
					r.rx_valid     = 1'b1;
					r.rx_byte      = bus.shifter;
					bus.reads_left = bus.reads_left - 8'd1;
					bus.sda_drive  = (bus.reads_left == 0);
					bus.phase      = PH_AK_HIGH;
				end
			end
			PH_AK_HIGH: begin
				bus.scl_drive = 1'b1;
				bus.phase     = PH_AK_DONE;
			end
			PH_AK_DONE: begin
				bus.scl_drive = 1'b0;
				if (bus.reads_left != 0)
					start_read();
				else
					send_stop();
			end
			PH_SP_SCL_HIGH: begin
				bus.scl_drive = 1'b1;
				bus.phase     = PH_SP_SDA_HIGH;
			end
			PH_SP_SDA_HIGH: begin
				bus.sda_drive = 1'b1;
				r.done_res    = 1'b1;
				r.status      = bus.result_code;
				bus.phase     = PH_IDLE;
			end
			default: begin
				bus.phase     = PH_IDLE;
				bus.scl_drive = 1'b1;
				bus.sda_drive = 1'b1;
			end
		endcase
		r.scl_out  = bus.scl_drive;
		r.sda_out  = bus.sda_drive;
		r.busy_res = (bus.phase != PH_IDLE);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("%t result %0d: %s", $realtime, result_no, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			bus                = '0;
			bus.phase          = PH_IDLE;
			bus.scl_drive      = 1'b1;
			bus.sda_drive      = 1'b1;
			regs               = '0;
			regs.ack_timeout   = ACK_TIMEOUT_RST;
			due_results.delete();
			result_no          = 0;
			errors             = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					want = due_results.pop_front();
					check_field("scl_out", rsp.scl_out, want.scl_out);
					check_field("sda_out", rsp.sda_out, want.sda_out);
					check_field("tx_taken", rsp.tx_taken, want.tx_taken);
					check_field("rx_byte", rsp.rx_byte, want.rx_byte);
					check_field("rx_valid", rsp.rx_valid, want.rx_valid);
					check_field("done_res", rsp.done_res, want.done_res);
					check_field("status", rsp.status, want.status);
					check_field("busy_res", rsp.busy_res, want.busy_res);
				end
				result_no++;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DEV_ADDR:    regs.device_address = cfg.data[6:0];
					REG_WRITE_COUNT: regs.write_count    = cfg.data;
					REG_READ_COUNT:  regs.read_count     = cfg.data;
					REG_ACK_TIMEOUT: regs.ack_timeout    = cfg.data;
					default: ;
				endcase
			end
			if (cmd.valid && cmd.ready)
				due_results.push_back(half_tick({cmd.opcode, cmd.sda_in, cmd.tx_byte}));
		end
		waiting     = due_results.size();
		xfer_active = (bus.phase != PH_IDLE);
	end

endmodule

// ===== test/i2c_master_transfer_top_test.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_top_test
// Stimulus and verdict for the I2C master transfer block.
// A short directed run covers idle ticks, a begin with both counts zero,
// a zero ack timeout and a begin while busy. Random phases follow, over
// several register settings and their extremes. Both channel sides idle at
// random, with one phase run at full rate and one long result hold-off.
// Checking is done in i2c_master_transfer_check.
// ----------------------------------------------------------------------------
module i2c_master_transfer_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import i2cm_pkg::*;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_BEGIN = 1'b1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   steady;
	bit   hold_req;
	int   fail_count;
	int   in_flight;
	logic bus_busy;

	i2cm_cmd_if cmd_ch();
	i2cm_rsp_if rsp_ch();
	i2cm_cfg_if cfg_ch();

	i2c_master_transfer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	i2c_master_transfer_check check_u (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.errors      (fail_count),
		.waiting     (in_flight),
		.xfer_active (bus_busy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic op, input logic sda, input logic [7:0] tx);
		while (!steady && $urandom_range(99) < 35) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.opcode  <= op;
		cmd_ch.sda_in  <= sda;
		cmd_ch.tx_byte <= tx;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic load_setup(input logic [6:0] addr, input logic [7:0] wc,
		input logic [7:0] rc, input logic [7:0] timeout);
		write_reg(REG_DEV_ADDR, {1'($urandom_range(1)), addr});
		write_reg(REG_WRITE_COUNT, wc);
		write_reg(REG_READ_COUNT, rc);
		write_reg(REG_ACK_TIMEOUT, timeout);
		cfg_ch.valid <= 1'b0;
	endtask

	// drain, then tick with SDA released until the transfer has stopped
	task automatic settle();
		int n;
		forever begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
			wait (in_flight == 0);
			repeat (4) @(posedge clk);
			if (!bus_busy)
				break;
			for (n = 0; n < 16; n++)
				send_item(OP_TICK, 1'b1, 8'($urandom));
		end
	endtask

	task automatic run_phase(input logic [6:0] addr, input logic [7:0] wc, input logic [7:0] rc,
		input logic [7:0] timeout, input int items, input int one_pct, input int begin_pct);
		int k;
		load_setup(addr, wc, rc, timeout);
		for (k = 0; k < items; k++)
			send_item($urandom_range(99) < begin_pct, $urandom_range(99) < one_pct,
				8'($urandom));
		settle();
	endtask

	initial begin : result_side
		int n;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && cmd_ch.valid) begin
				hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				for (n = 0; n < 100; n++)
					@(posedge clk);
			end
			rsp_ch.ready <= steady || ($urandom_range(99) >= 35);
		end
	end

	initial begin : stimulus
		int k;
		int p;
		cmd_ch.valid   = 1'b0;
		cmd_ch.opcode  = OP_TICK;
		cmd_ch.sda_in  = 1'b1;
		cmd_ch.tx_byte = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_DEV_ADDR;
		cfg_ch.data    = '0;
		rsp_ch.ready   = 1'b0;
		steady         = 1'b0;
		hold_req       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick, then begin with reset counts: parameter error
		send_item(OP_TICK, 1'b1, 8'hFF);
		send_item(OP_BEGIN, 1'b0, 8'h00);
		send_item(OP_TICK, 1'b0, 8'h00);
		send_item(OP_TICK, 1'b1, 8'hFF);
		settle();

		// zero ack timeout, begin while busy, byte taken at the address ack
		load_setup(7'h7F, 8'd1, 8'd1, 8'd0);
		send_item(OP_BEGIN, 1'b0, 8'hFF);
		for (k = 0; k <= 20; k++)
			send_item((k == 9) ? OP_BEGIN : OP_TICK, 1'b0, k[0] ? 8'h00 : 8'hFF);
		settle();

		run_phase(7'h7F, 8'd255, 8'd255, 8'd1, 160, 50, 10);
		run_phase(7'h00, 8'd0, 8'd0, 8'd200, 60, 50, 20);
		steady = 1'b1;
		run_phase(7'h00, 8'd0, 8'd2, 8'd255, 220, 50, 10);
		steady = 1'b0;
		hold_req = 1'b1;
		run_phase(7'($urandom_range(127)), 8'd2, 8'd2, 8'd2, 260, 20, 8);
		for (p = 0; p < 4; p++)
			run_phase(7'($urandom_range(127)), 8'($urandom_range(4, 1)),
				8'($urandom_range(3)), 8'($urandom_range(3)), 220, 20, 8);

		repeat (8) @(posedge clk);
		if (fail_count == 0 && in_flight == 0)
			$display("** i2c_master_transfer_top: PASSED **");
		else
			$display("** i2c_master_transfer_top: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("** i2c_master_transfer_top: FAILED **");
		$finish;
	end

endmodule
